### src/idll_pkg.sv
`timescale 1ns / 1ps

package idll_pkg;

	localparam int IDLL_NODES = 64;

	localparam int REQ_W       = 2;
	localparam int NODE_W      = 6;
	localparam int LEN_W       = 7;
	localparam int LEN_CAP     = 127;

	typedef enum logic [REQ_W-1:0] {
		REQ_LINK   = 2'd0,
		REQ_UNLINK = 2'd1,
		REQ_COUNT  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_UL1   = 6'b000100,
		ST_UL2   = 6'b001000,
		ST_WALK  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

endpackage

### src/indexed_doubly_linked_list.sv
// Link: tables written in the accept cycle. Unlink: read, splice, clear.
// Count: the result follows a forward and a backward walk, each visiting at most NODES nodes,
//   and waits while the result slot is full; one table read per visited node.
// Throughput: one request at a time; in_ready is high only when the sequencer is idle.
// Reset: arst_n clears control state, then a clearing pass writes every table entry empty,
//   one entry per cycle, with in_ready low.
`timescale 1ns / 1ps

module indexed_doubly_linked_list
	import idll_pkg::*;
#(
	parameter int NODES = IDLL_NODES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [NODE_W-1:0] node_a,
	input  logic [NODE_W-1:0] node_b,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [LEN_W-1:0]  chain_length,
	output logic              walk_overflow
);

	localparam int IW      = $clog2(NODES);
	localparam int CW      = $clog2(NODES + 1);
	localparam int LW      = CW + 1;
	localparam int LEN_MAX = (NODES < LEN_CAP) ? NODES : LEN_CAP;

	typedef logic [IW-1:0] idx_t;
	typedef logic [CW-1:0] cnt_t;

	typedef struct packed {
		logic ok;
		idx_t to;
	} link_t;

	link_t  nxt_mem [NODES];
	link_t  prv_mem [NODES];
	link_t  nxt_rd_q, prv_rd_q;

	state_t state_q;
	idx_t   clr_q;
	idx_t   a_q;
	logic   dir_q;
	logic   over_q;
	cnt_t   cnt_q;
	cnt_t   fwd_q;

	logic   out_valid_q;
	logic [LEN_W-1:0] chain_length_q;
	logic   walk_overflow_q;

	logic   in_acc;
	req_t   req;
	logic   a_in_range, b_in_range;
	idx_t   rd_addr;
	logic   nxt_we, prv_we;
	idx_t   nxt_wa, prv_wa;
	link_t  nxt_wd, prv_wd;
	link_t  walk_e;
	logic   at_bound;
	logic   slot_free;
	logic [LW-1:0] len_sum;
	logic [LW-1:0] len_sat;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign req        = req_t'(req_type);
	assign a_in_range = (32'(node_a) < NODES);
	assign b_in_range = (32'(node_b) < NODES);
	assign walk_e     = dir_q ? prv_rd_q : nxt_rd_q;
	assign at_bound   = (cnt_q >= cnt_t'(NODES));
	assign slot_free  = !out_valid_q || out_ready;
	assign len_sum    = LW'(fwd_q) + LW'(cnt_q) - LW'(1);
	assign len_sat    = (len_sum > LW'(LEN_MAX)) ? LW'(LEN_MAX) : len_sum;

	// read address: request node in idle (except for count requests), else follow the link being walked
	always_comb begin
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req != REQ_COUNT)
					rd_addr = idx_t'(node_a);
			end
			ST_WALK: begin
				if (walk_e.ok && !at_bound)
					rd_addr = walk_e.to;
			end
			ST_CLEAR, ST_UL1, ST_UL2, ST_DONE: rd_addr = '0;
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		nxt_we = 1'b0;
		nxt_wa = '0;
		nxt_wd = '0;
		prv_we = 1'b0;
		prv_wa = '0;
		prv_wd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				nxt_we = 1'b1;
				nxt_wa = clr_q;
				prv_we = 1'b1;
				prv_wa = clr_q;
			end
			ST_IDLE: begin
				if (in_acc && req == REQ_LINK && a_in_range && b_in_range) begin
					nxt_we = 1'b1;
					nxt_wa = idx_t'(node_a);
					nxt_wd = '{ok: 1'b1, to: idx_t'(node_b)};
					prv_we = 1'b1;
					prv_wa = idx_t'(node_b);
					prv_wd = '{ok: 1'b1, to: idx_t'(node_a)};
				end
			end
			ST_UL1: begin
				// splice: neighbors take over the removed node's links
				prv_we = nxt_rd_q.ok;
				prv_wa = nxt_rd_q.to;
				prv_wd = prv_rd_q;
				nxt_we = prv_rd_q.ok;
				nxt_wa = prv_rd_q.to;
				nxt_wd = nxt_rd_q;
			end
			ST_UL2: begin
				nxt_we = 1'b1;
				nxt_wa = a_q;
				prv_we = 1'b1;
				prv_wa = a_q;
			end
			ST_WALK, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (nxt_we)
			nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we)
			prv_mem[prv_wa] <= prv_wd;
		nxt_rd_q <= nxt_mem[rd_addr];
		prv_rd_q <= prv_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			dir_q   <= 1'b0;
			over_q  <= 1'b0;
			cnt_q   <= '0;
			fwd_q   <= '0;
			a_q     <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + idx_t'(1);
					if (clr_q == idx_t'(NODES - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						a_q    <= idx_t'(node_a);
						dir_q  <= 1'b0;
						over_q <= 1'b0;
						cnt_q  <= cnt_t'(1);
						if (req == REQ_UNLINK && a_in_range)
							state_q <= ST_UL1;
						else if (req == REQ_COUNT)
							state_q <= ST_WALK;
					end
				end
				ST_UL1: state_q <= ST_UL2;
				ST_UL2: state_q <= ST_IDLE;
				ST_WALK: begin
					if (walk_e.ok && !at_bound) begin
						cnt_q <= cnt_q + cnt_t'(1);
					end else begin
						if (walk_e.ok)
							over_q <= 1'b1;
						if (!dir_q) begin
							fwd_q <= cnt_q;
							cnt_q <= cnt_t'(1);
							dir_q <= 1'b1;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			chain_length_q  <= LEN_W'(len_sat);
			walk_overflow_q <= over_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign chain_length  = chain_length_q;
	assign walk_overflow = walk_overflow_q;

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside the done state");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (cnt_q <= cnt_t'(NODES)) && (cnt_q != '0))
		else $error("walk counter out of bounds");

	a_unlink_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req == REQ_UNLINK && a_in_range) |=> (state_q == ST_UL1) ##1
		(state_q == ST_UL2) ##1 (state_q == ST_IDLE))
		else $error("unlink sequence broken");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !slot_free) |=> (state_q == ST_DONE))
		else $error("count finished while result slot occupied");

endmodule
